// ----- src/assert_macros.svh -----
// Assertion helpers shared by the files that check their own logic.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/sfcd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfcd_pkg
// Types, constants and the weight lookup for the frame change detector.
// ----------------------------------------------------------------------------
package sfcd_pkg;

  localparam int PIX_W    = 8;
  localparam int WEIGHT_W = 10;  // three weights of at most 255 each
  localparam int THRESH_W = 32;
  localparam int TOTAL_W  = 32;

  localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 32'd2500;
  localparam logic [TOTAL_W-1:0]  TOTAL_MAX       = 32'hFFFF_FFFF;

  typedef logic [PIX_W-1:0]    pix_t;
  typedef logic [1:0]          phase_t;
  typedef logic [WEIGHT_W-1:0] weight_t;

  // Phases count 0, 1, 2 and wrap.
  localparam phase_t PHASE_LAST = 2'd2;

  localparam logic [7:0] WEIGHT_TABLE [0:16] = '{
    8'd0,   8'd1,   8'd3,   8'd10,  8'd10,  8'd20,  8'd20,  8'd40,  8'd40,
    8'd80,  8'd80,  8'd160, 8'd160, 8'd255, 8'd255, 8'd255, 8'd255
  };

  function automatic logic [7:0] channel_weight(input pix_t a, input pix_t b);
    pix_t d;
    d = (a >= b) ? (a - b) : (b - a);
    return WEIGHT_TABLE[{1'b0, d[7:4]}];
  endfunction

endpackage

// ----- src/sfcd_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfcd_pix_if / sfcd_res_if
// Valid/ready channels for pixel pairs in and frame results out.
// ----------------------------------------------------------------------------
interface sfcd_pix_if;
  logic          valid;
  logic          ready;
  sfcd_pkg::pix_t cur_red;
  sfcd_pkg::pix_t cur_green;
  sfcd_pkg::pix_t cur_blue;
  sfcd_pkg::pix_t ref_red;
  sfcd_pkg::pix_t ref_green;
  sfcd_pkg::pix_t ref_blue;
  logic          first_of_frame;
  logic          last_of_row;
  logic          last_of_frame;

  modport source (
    output valid, cur_red, cur_green, cur_blue, ref_red, ref_green, ref_blue,
           first_of_frame, last_of_row, last_of_frame,
    input  ready
  );
  modport sink (
    input  valid, cur_red, cur_green, cur_blue, ref_red, ref_green, ref_blue,
           first_of_frame, last_of_row, last_of_frame,
    output ready
  );
endinterface

interface sfcd_res_if;
  logic                         valid;
  logic                         ready;
  logic                         frame_changed;
  logic [sfcd_pkg::TOTAL_W-1:0] total_difference;

  modport source (
    output valid, frame_changed, total_difference,
    input  ready
  );
  modport sink (
    input  valid, frame_changed, total_difference,
    output ready
  );
endinterface

// ----- src/sfcd_weight.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfcd_weight
// Weighted RGB difference of one pixel pair: abs diff, >> 4, table, sum.
// ----------------------------------------------------------------------------
module sfcd_weight (
  input  sfcd_pkg::pix_t    cur_red,
  input  sfcd_pkg::pix_t    cur_green,
  input  sfcd_pkg::pix_t    cur_blue,
  input  sfcd_pkg::pix_t    ref_red,
  input  sfcd_pkg::pix_t    ref_green,
  input  sfcd_pkg::pix_t    ref_blue,
  output sfcd_pkg::weight_t weight
);

  logic [7:0] w_red;
  logic [7:0] w_green;
  logic [7:0] w_blue;

  assign w_red   = sfcd_pkg::channel_weight(cur_red, ref_red);
  assign w_green = sfcd_pkg::channel_weight(cur_green, ref_green);
  assign w_blue  = sfcd_pkg::channel_weight(cur_blue, ref_blue);

  assign weight = sfcd_pkg::WEIGHT_W'(w_red) + sfcd_pkg::WEIGHT_W'(w_green)
                + sfcd_pkg::WEIGHT_W'(w_blue);

endmodule

// ----- src/subsampled_frame_change_detector_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subsampled_frame_change_detector_core
// Frame difference change detector over a 1-in-3 by 1-in-3 pixel grid.
// ----------------------------------------------------------------------------
// Takes one pixel pair per clock, sustained. A transfer lands in an input
// register; as it leaves that register it is folded into the row/column
// phases and the saturating SUM_WIDTH-bit sum, and the last pixel of a frame
// also loads the result register, which offers the result. The only stall is
// a last-of-frame pixel meeting a result that has not been taken yet. The
// threshold compare uses the full sum; the reported total saturates at 32
// bits. Write the threshold only while the block idles.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module subsampled_frame_change_detector_core #(
  parameter int SUM_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  sfcd_pix_if.sink                      in_ch,
  sfcd_res_if.source                    out_ch,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sfcd_pkg::THRESH_W-1:0] cfg_data
);

  localparam int CMP_W = (SUM_WIDTH > sfcd_pkg::TOTAL_W) ? SUM_WIDTH : sfcd_pkg::TOTAL_W;

  // input register
  logic           a_valid_r;
  sfcd_pkg::pix_t a_cur_red_r, a_cur_green_r, a_cur_blue_r;
  sfcd_pkg::pix_t a_ref_red_r, a_ref_green_r, a_ref_blue_r;
  logic           a_first_r, a_row_end_r, a_last_r;

  // running state
  sfcd_pkg::phase_t         col_r, col_nxt;
  sfcd_pkg::phase_t         row_r, row_nxt;
  logic [SUM_WIDTH-1:0]     sum_r, sum_nxt;
  logic [sfcd_pkg::THRESH_W-1:0] thresh_r;

  // result register
  logic                         out_valid_r;
  logic                         out_changed_r, out_changed_nxt;
  logic [sfcd_pkg::TOTAL_W-1:0] out_total_r, out_total_nxt;

  logic                 advance_a;
  logic                 in_xfer;
  sfcd_pkg::weight_t    weight;
  sfcd_pkg::phase_t     col_base, row_base;
  logic [SUM_WIDTH-1:0] sum_base;
  logic [SUM_WIDTH:0]   sum_add;
  logic [SUM_WIDTH-1:0] sum_new;
  logic [CMP_W-1:0]     sum_cmp;

  // hold a last-of-frame pixel while the previous result is still waiting
  assign advance_a   = a_valid_r && (!a_last_r || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !a_valid_r || advance_a;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign cfg_ready   = 1'b1;

  sfcd_weight u_weight (
    .cur_red   (a_cur_red_r),
    .cur_green (a_cur_green_r),
    .cur_blue  (a_cur_blue_r),
    .ref_red   (a_ref_red_r),
    .ref_green (a_ref_green_r),
    .ref_blue  (a_ref_blue_r),
    .weight    (weight)
  );

  always_comb begin
    col_base = a_first_r ? '0 : col_r;
    row_base = a_first_r ? '0 : row_r;
    sum_base = a_first_r ? '0 : sum_r;

    if (col_base == '0 && row_base == '0) begin
      sum_add = {1'b0, sum_base} + (SUM_WIDTH + 1)'(weight);
    end else begin
      sum_add = {1'b0, sum_base};
    end
    sum_new = sum_add[SUM_WIDTH] ? '1 : sum_add[SUM_WIDTH-1:0];
    sum_cmp = CMP_W'(sum_new);

    out_changed_nxt = sum_cmp > CMP_W'(thresh_r);
    out_total_nxt   = (sum_cmp > CMP_W'(sfcd_pkg::TOTAL_MAX)) ? sfcd_pkg::TOTAL_MAX
                                                             : sum_cmp[sfcd_pkg::TOTAL_W-1:0];

    if (a_last_r) begin
      col_nxt = '0;
      row_nxt = '0;
      sum_nxt = '0;
    end else begin
      sum_nxt = sum_new;
      if (a_row_end_r) begin
        col_nxt = '0;
        row_nxt = (row_base >= sfcd_pkg::PHASE_LAST) ? '0 : row_base + 2'd1;
      end else begin
        col_nxt = (col_base >= sfcd_pkg::PHASE_LAST) ? '0 : col_base + 2'd1;
        row_nxt = row_base;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
      sum_r       <= '0;
      thresh_r    <= sfcd_pkg::THRESHOLD_RESET;
    end else begin
      if (in_ch.ready) begin
        a_valid_r <= in_ch.valid;
      end
      if (advance_a) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
        sum_r <= sum_nxt;
      end
      if (advance_a && a_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        thresh_r <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      a_cur_red_r   <= in_ch.cur_red;
      a_cur_green_r <= in_ch.cur_green;
      a_cur_blue_r  <= in_ch.cur_blue;
      a_ref_red_r   <= in_ch.ref_red;
      a_ref_green_r <= in_ch.ref_green;
      a_ref_blue_r  <= in_ch.ref_blue;
      a_first_r     <= in_ch.first_of_frame;
      a_row_end_r   <= in_ch.last_of_row;
      a_last_r      <= in_ch.last_of_frame;
    end
    if (advance_a && a_last_r) begin
      out_changed_r <= out_changed_nxt;
      out_total_r   <= out_total_nxt;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.frame_changed    = out_changed_r;
  assign out_ch.total_difference = out_total_r;

  `ASSERT_NXT(a_result_loaded, advance_a && a_last_r, out_valid_r,
              "frame end did not load a result")
  `ASSERT_NXT(a_frame_clears, advance_a && a_last_r,
              sum_r == '0 && col_r == '0 && row_r == '0,
              "state not cleared after frame end")
  `ASSERT_NXT(a_sum_monotonic, advance_a && !a_first_r && !a_last_r,
              sum_r >= $past(sum_r), "sum decreased inside a frame")
  `ASSERT_IMP(a_phase_range, 1'b1,
              col_r <= sfcd_pkg::PHASE_LAST && row_r <= sfcd_pkg::PHASE_LAST,
              "phase counter out of range")

endmodule
